[rtl/ode_residual_stencil_core_defines.svh]
// Assertion macros shared by the stencil core RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk,
// held off while rst_n is low; in synthesis builds each expands to nothing.
`ifndef ODE_RESIDUAL_STENCIL_CORE_DEFINES_SVH
`define ODE_RESIDUAL_STENCIL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ORS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stencil core assertion failed");
// next-cycle implication
`define ORS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stencil core assertion failed");
`else
`define ORS_ASSERT_IMP(lbl, ante, cons)
`define ORS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/ors_pkg.sv]
`default_nettype none

package ors_pkg;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int RES_W    = 48;
    localparam int IDX_W    = 12;
    localparam int STEP_W   = 32;
    localparam int INV_W    = 48;
    localparam int NCFG_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 48;

    // Stencil numerator width: five Q16.16 samples plus 4*step fit here
    localparam int SW = 38;

    // Multiplier operand width (signed, covers every numerator and d2)
    localparam int MOP_W = 49;
    localparam int MAG_W = 48;
    localparam int CHUNK_W = 16;
    localparam int PP_W = MAG_W + CHUNK_W;
    localparam int ACC_W = 2 * MAG_W;
    localparam int WIDE_W = ACC_W + 2;

    // Multiplier sequence steps
    localparam logic [2:0] PH_PP0 = 3'd0;
    localparam logic [2:0] PH_PP1 = 3'd1;
    localparam logic [2:0] PH_PP2 = 3'd2;
    localparam logic [2:0] PH_ACC = 3'd3;
    localparam logic [2:0] PH_SGN = 3'd4;
    localparam logic [2:0] PH_SAT = 3'd5;

    // Cell count limits and register resets
    localparam int MIN_CELLS = 5;
    localparam logic [NCFG_W-1:0] NUM_CELLS_RST = 13'd1000;
    localparam logic [STEP_W-1:0] GRID_STEP_RST = 32'd328;
    localparam logic [INV_W-1:0]  INV_SQ_RST    = 48'd2616199741;
    localparam logic [INV_W-1:0]  INV_CUBE_RST  = 48'd522716708864;

    // Number of entries the final sample of a vector produces
    localparam logic [1:0] FINAL_ENTRIES = 2'd3;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic signed [RES_W-1:0] SAT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [RES_W-1:0] SAT_MIN = 48'sh8000_0000_0000;

    typedef logic signed [SW-1:0] sw_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_CELLS = 2'd0,
        REG_GRID_STEP = 2'd1,
        REG_INV_SQ    = 2'd2,
        REG_INV_CUBE  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ENT_PASS = 2'd0,
        ENT_MID  = 2'd1,
        ENT_NEAR = 2'd2,
        ENT_END  = 2'd3
    } ent_kind_t;

    typedef struct packed {
        logic                        is_pass;
        logic signed [SW-1:0]        s;
        logic signed [SW-1:0]        d;
        logic signed [SAMPLE_W-1:0]  fi;
        logic [IDX_W-1:0]            idx;
        logic                        last;
        logic                        done;
    } ors_entry_t;

    typedef struct packed {
        logic start;
        logic k17;
    } mul_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_D3_GO   = 4'd1,
        ST_D3_WAIT = 4'd2,
        ST_D2_GO   = 4'd3,
        ST_D2_WAIT = 4'd4,
        ST_P_GO    = 4'd5,
        ST_P_WAIT  = 4'd6,
        ST_SUB     = 4'd7,
        ST_OUT     = 4'd8
    } back_state_t;

    // Clamp a wide signed value to the signed 48-bit range
    function automatic logic signed [RES_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
        logic hi_zero;
        logic hi_ones;
        hi_zero = (v[WIDE_W-1:RES_W-1] == '0);
        hi_ones = (v[WIDE_W-1:RES_W-1] == '1);
        if (hi_zero || hi_ones)
            sat48 = v[RES_W-1:0];
        else if (v[WIDE_W-1])
            sat48 = SAT_MIN;
        else
            sat48 = SAT_MAX;
    endfunction

endpackage

`default_nettype wire

[rtl/ors_front.sv]
`default_nettype none

module ors_front
    import ors_pkg::*;
#(
    parameter int MAX_CELLS = 4096
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [NCFG_W-1:0]       num_cells,
    input  wire logic [STEP_W-1:0]       grid_step,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [SAMPLE_W-1:0]     in_sample,
    output logic                         push,
    output ors_entry_t                   push_data,
    input  wire logic                    q_full
);

    localparam int CW = ($clog2(MAX_CELLS + 1) > NCFG_W) ? $clog2(MAX_CELLS + 1) : NCFG_W;

    logic signed [SAMPLE_W-1:0] win_reg [0:4];
    logic [CW-1:0]              cnt_reg;
    logic [1:0]                 pend_reg;
    ent_kind_t                  kind_reg;
    logic [CW-1:0]              idx_reg;

    logic [CW-1:0] n_raw;
    logic [CW-1:0] n_cells;
    logic          accept;
    sw_t           a, b, c, d, e, h;
    ent_kind_t     kind_adv;

    // Clamp the cell count into its legal range
    always_comb
    begin
        n_raw = CW'(num_cells);
        if (n_raw < CW'(MIN_CELLS))
            n_cells = CW'(MIN_CELLS);
        else if (n_raw > CW'(MAX_CELLS))
            n_cells = CW'(MAX_CELLS);
        else
            n_cells = n_raw;
    end

    assign in_ready = (pend_reg == 2'd0);
    assign accept   = in_valid && in_ready;
    assign push     = (pend_reg != 2'd0) && !q_full;

    // Window taps, oldest first
    assign a = sw_t'(win_reg[0]);
    assign b = sw_t'(win_reg[1]);
    assign c = sw_t'(win_reg[2]);
    assign d = sw_t'(win_reg[3]);
    assign e = sw_t'(win_reg[4]);
    assign h = sw_t'(grid_step);

    // Build the stencil numerators for the pending entry
    always_comb
    begin
        push_data.is_pass = (kind_reg == ENT_PASS);
        push_data.idx     = idx_reg[IDX_W-1:0];
        push_data.last    = (pend_reg == 2'd1);
        push_data.done    = (kind_reg == ENT_END);
        case (kind_reg)
            ENT_PASS:
            begin
                push_data.s  = '0;
                push_data.d  = '0;
                push_data.fi = win_reg[4];
            end
            ENT_MID:
            begin
                push_data.s  = -a + (b <<< 1) - (d <<< 1) + e;
                push_data.d  = b - (c <<< 1) + d;
                push_data.fi = win_reg[2];
            end
            ENT_NEAR:
            begin
                push_data.s  = -b + (c <<< 1) + d - (e <<< 1) + (h <<< 2);
                push_data.d  = c - (d <<< 1) + e;
                push_data.fi = win_reg[3];
            end
            default:
            begin
                push_data.s  = e - c - (h <<< 2);
                push_data.d  = d - e + (h <<< 1);
                push_data.fi = win_reg[4];
            end
        endcase
    end

    // Step through the three closing entries of a vector
    always_comb
    begin
        case (kind_reg)
            ENT_MID:  kind_adv = ENT_NEAR;
            ENT_NEAR: kind_adv = ENT_END;
            default:  kind_adv = ENT_END;
        endcase
    end

    // Shift the window, count samples and schedule entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
                win_reg[i] <= '0;
            cnt_reg  <= '0;
            pend_reg <= '0;
            kind_reg <= ENT_PASS;
            idx_reg  <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < 4; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[4] <= $signed(in_sample);
            if (cnt_reg >= n_cells - CW'(1))
            begin
                cnt_reg  <= '0;
                pend_reg <= FINAL_ENTRIES;
                kind_reg <= ENT_MID;
                idx_reg  <= n_cells - CW'(3);
            end
            else
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg < CW'(2))
                begin
                    pend_reg <= 2'd1;
                    kind_reg <= ENT_PASS;
                    idx_reg  <= cnt_reg;
                end
                else if (cnt_reg >= CW'(4))
                begin
                    pend_reg <= 2'd1;
                    kind_reg <= ENT_MID;
                    idx_reg  <= cnt_reg - CW'(2);
                end
                else
                begin
                    pend_reg <= 2'd0;
                end
            end
        end
        else if (push)
        begin
            pend_reg <= pend_reg - 2'd1;
            if (pend_reg != 2'd1)
            begin
                kind_reg <= kind_adv;
                idx_reg  <= idx_reg + CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/ors_queue.sv]
`default_nettype none

module ors_queue
    import ors_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire ors_entry_t push_data,
    output logic            full,
    input  wire logic       pop,
    output logic            valid,
    output ors_entry_t      head
);

    ors_entry_t        q_mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW:0]     count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = q_mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (Q_AW+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (Q_AW+1)'(1);
        end
    end

endmodule

`default_nettype wire

[rtl/ors_mul.sv]
`default_nettype none

module ors_mul
    import ors_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mul_ctrl_t                ctrl,
    input  wire logic signed [MOP_W-1:0]  op_a,
    input  wire logic signed [MOP_W-1:0]  op_b,
    output mul_stat_t                     stat,
    output logic signed [RES_W-1:0]       result
);

    logic [MAG_W-1:0]          a_mag_reg;
    logic [MAG_W-1:0]          b_mag_reg;
    logic                      neg_reg;
    logic                      k17_reg;
    logic [2:0]                phase_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [PP_W-1:0]           pp_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic signed [WIDE_W-1:0]  sgn_reg;
    logic signed [RES_W-1:0]   res_reg;

    logic [MOP_W-1:0]          a_abs;
    logic [MOP_W-1:0]          b_abs;
    logic [CHUNK_W-1:0]        chunk;
    logic [PP_W-1:0]           pp_calc;
    logic signed [WIDE_W-1:0]  shifted;

    assign a_abs = op_a[MOP_W-1] ? MOP_W'(-op_a) : MOP_W'(op_a);
    assign b_abs = op_b[MOP_W-1] ? MOP_W'(-op_b) : MOP_W'(op_b);

    // Pick the 16-bit slice of b for this step
    always_comb
    begin
        case (phase_reg)
            PH_PP0:  chunk = b_mag_reg[CHUNK_W-1:0];
            PH_PP1:  chunk = b_mag_reg[2*CHUNK_W-1:CHUNK_W];
            PH_PP2:  chunk = b_mag_reg[3*CHUNK_W-1:2*CHUNK_W];
            default: chunk = '0;
        endcase
    end

    assign pp_calc = a_mag_reg * chunk;
    assign shifted = k17_reg ? (sgn_reg >>> 17) : (sgn_reg >>> 16);

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

    // Busy flag, done flag and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= PH_PP0;
        end
        else
        begin
            done_reg <= busy_reg && (phase_reg == PH_SAT);
            if (ctrl.start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_PP0;
            end
            else if (busy_reg)
            begin
                if (phase_reg == PH_SAT)
                    busy_reg <= 1'b0;
                phase_reg <= phase_reg + 3'd1;
            end
        end
    end

    // Operand capture, partial products, accumulate, sign, shift and clamp
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            a_mag_reg <= a_abs[MAG_W-1:0];
            b_mag_reg <= b_abs[MAG_W-1:0];
            neg_reg   <= op_a[MOP_W-1] ^ op_b[MOP_W-1];
            k17_reg   <= ctrl.k17;
        end
        pp_reg <= pp_calc;
        if (busy_reg)
        begin
            case (phase_reg)
                PH_PP1:  acc_reg <= ACC_W'(pp_reg);
                PH_PP2:  acc_reg <= acc_reg + {16'd0, pp_reg, 16'd0};
                PH_ACC:  acc_reg <= acc_reg + {pp_reg, 32'd0};
                PH_SGN:  sgn_reg <= neg_reg ? -$signed({2'b00, acc_reg})
                                            : $signed({2'b00, acc_reg});
                PH_SAT:  res_reg <= sat48(shifted);
                default: acc_reg <= acc_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/ors_back.sv]
`default_nettype none

`include "ode_residual_stencil_core_defines.svh"

module ors_back
    import ors_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [INV_W-1:0]       inv_step_sq,
    input  wire logic [INV_W-1:0]       inv_step_cube,
    input  wire logic                   q_valid,
    input  wire ors_entry_t             q_head,
    output logic                        q_pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [RES_W-1:0]     out_residual,
    output logic [IDX_W-1:0]            out_index,
    output logic                        out_last,
    output logic                        out_done
);

    back_state_t               state_reg;
    back_state_t               state_next;
    ors_entry_t                ent_reg;
    logic signed [RES_W-1:0]   d3_reg;
    logic signed [RES_W-1:0]   d2_reg;
    logic signed [RES_W-1:0]   p_reg;
    logic signed [RES_W-1:0]   res_reg;
    logic                      out_valid_reg;
    logic signed [RES_W-1:0]   out_res_reg;
    logic [IDX_W-1:0]          out_idx_reg;
    logic                      out_last_reg;
    logic                      out_done_reg;

    mul_ctrl_t                 mul_ctrl;
    mul_stat_t                 mul_stat;
    logic signed [MOP_W-1:0]   mul_a;
    logic signed [MOP_W-1:0]   mul_b;
    logic signed [RES_W-1:0]   mul_res;
    logic                      out_load;
    logic signed [RES_W:0]     diff;

    ors_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mul_ctrl),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .stat   (mul_stat),
        .result (mul_res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                    state_next = q_head.is_pass ? ST_OUT : ST_D3_GO;
            end
            ST_D3_GO:   state_next = ST_D3_WAIT;
            ST_D3_WAIT: if (mul_stat.done) state_next = ST_D2_GO;
            ST_D2_GO:   state_next = ST_D2_WAIT;
            ST_D2_WAIT: if (mul_stat.done) state_next = ST_P_GO;
            ST_P_GO:    state_next = ST_P_WAIT;
            ST_P_WAIT:  if (mul_stat.done) state_next = ST_SUB;
            ST_SUB:     state_next = ST_OUT;
            ST_OUT:     if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // State outputs: pop, multiplier issue and operand select, output load
    always_comb
    begin
        q_pop          = (state_reg == ST_IDLE) && q_valid;
        out_load       = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
        mul_ctrl.start = 1'b0;
        mul_ctrl.k17   = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        case (state_reg)
            ST_D3_GO:
            begin
                mul_ctrl.start = 1'b1;
                mul_ctrl.k17   = 1'b1;
                mul_a          = MOP_W'(ent_reg.s);
                mul_b          = $signed({1'b0, inv_step_cube});
            end
            ST_D2_GO:
            begin
                mul_ctrl.start = 1'b1;
                mul_a          = MOP_W'(ent_reg.d);
                mul_b          = $signed({1'b0, inv_step_sq});
            end
            ST_P_GO:
            begin
                mul_ctrl.start = 1'b1;
                mul_a          = MOP_W'(ent_reg.fi);
                mul_b          = MOP_W'(d2_reg);
            end
            default:
            begin
                mul_ctrl.start = 1'b0;
            end
        endcase
    end

    assign diff = (RES_W+1)'(d3_reg) - (RES_W+1)'(p_reg);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the entry and the intermediate derivatives
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ent_reg <= q_head;
            res_reg <= RES_W'(q_head.fi);
        end
        if (state_reg == ST_D3_WAIT && mul_stat.done)
            d3_reg <= mul_res;
        if (state_reg == ST_D2_WAIT && mul_stat.done)
            d2_reg <= mul_res;
        if (state_reg == ST_P_WAIT && mul_stat.done)
            p_reg <= mul_res;
        if (state_reg == ST_SUB)
            res_reg <= sat48(WIDE_W'(diff));
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg  <= res_reg;
            out_idx_reg  <= ent_reg.idx;
            out_last_reg <= ent_reg.last;
            out_done_reg <= ent_reg.done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_residual = out_res_reg;
    assign out_index    = out_idx_reg;
    assign out_last     = out_last_reg;
    assign out_done     = out_done_reg;

    `ORS_ASSERT_IMP(a_mul_free, mul_ctrl.start, !mul_stat.busy)
    `ORS_ASSERT_IMP(a_out_no_clobber, out_load, !out_valid_reg || out_ready)
    `ORS_ASSERT_IMP(a_done_awaited, mul_stat.done,
        state_reg == ST_D3_WAIT || state_reg == ST_D2_WAIT || state_reg == ST_P_WAIT)
    `ORS_ASSERT_NEXT(a_pop_leaves_idle, q_pop, state_reg != ST_IDLE)

endmodule

`default_nettype wire

[rtl/ode_residual_stencil_core.sv]
// Residual stencil core for a third-order ODE on a uniform grid.
// Input stream: one signed Q16.16 grid sample per word on s_axis, in index
// order; a vector holds num_cells samples (clamped to 5 .. MAX_CELLS).
// Output stream: residual words on m_axis, signed Q32.16 saturated, with
// the grid index; tlast marks the last word caused by one input sample,
// tuser marks the residual of the final grid index of a vector.
// Samples 0 and 1 come back unchanged, samples 2 and 3 produce nothing,
// later samples produce the residual two indices back, and the final
// sample of a vector produces three words.
// The front takes a sample only once the entries of the previous sample
// are in the 4-entry queue. The back computes each residual with three
// 48x48 products on one 48x16 multiplier, one entry at a time, taking the
// next entry only once the last is in the output word; a pass-through
// word skips the multiplier. Reset clears the window, the sample count,
// the queue and the output valid flag, and loads the default configuration.
// Configuration is written through cfg_we/cfg_index/cfg_data while the
// stream is idle; the user ensures this, the block does not enforce it.
// When m_axis_tready is low the output word holds, the back stalls, the
// queue fills and s_axis_tready drops; nothing is lost.
`default_nettype none

module ode_residual_stencil_core
    import ors_pkg::*;
#(
    parameter int MAX_CELLS = 4096
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [31:0]            s_axis_tdata,   // [31:0] sample
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [63:0]                 m_axis_tdata,   // [47:0] residual, [59:48] grid_index
    output logic                        m_axis_tlast,
    output logic [0:0]                  m_axis_tuser    // [0] vector_done
);

    logic [NCFG_W-1:0]  num_cells_reg;
    logic [STEP_W-1:0]  grid_step_reg;
    logic [INV_W-1:0]   inv_sq_reg;
    logic [INV_W-1:0]   inv_cube_reg;

    logic               push;
    ors_entry_t         push_data;
    logic               q_full;
    logic               q_valid;
    ors_entry_t         q_head;
    logic               q_pop;

    logic signed [RES_W-1:0] out_residual;
    logic [IDX_W-1:0]        out_index;
    logic                    out_last;
    logic                    out_done;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cells_reg <= NUM_CELLS_RST;
            grid_step_reg <= GRID_STEP_RST;
            inv_sq_reg    <= INV_SQ_RST;
            inv_cube_reg  <= INV_CUBE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NUM_CELLS: num_cells_reg <= cfg_data[NCFG_W-1:0];
                REG_GRID_STEP: grid_step_reg <= cfg_data[STEP_W-1:0];
                REG_INV_SQ:    inv_sq_reg    <= cfg_data[INV_W-1:0];
                REG_INV_CUBE:  inv_cube_reg  <= cfg_data[INV_W-1:0];
                default:       num_cells_reg <= num_cells_reg;
            endcase
        end
    end

    ors_front #(
        .MAX_CELLS (MAX_CELLS)
    ) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_cells (num_cells_reg),
        .grid_step (grid_step_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    ors_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    ors_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .inv_step_sq   (inv_sq_reg),
        .inv_step_cube (inv_cube_reg),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_residual  (out_residual),
        .out_index     (out_index),
        .out_last      (out_last),
        .out_done      (out_done)
    );

    // Pack the output word
    assign m_axis_tdata    = {4'd0, out_index, out_residual};
    assign m_axis_tlast    = out_last;
    assign m_axis_tuser[0] = out_done;

endmodule

`default_nettype wire
